@@ hdl/stochastic_oscillator_defines.svh @@
// assertion macros shared by the stochastic oscillator modules
`ifndef STOCHASTIC_OSCILLATOR_DEFINES_SVH
`define STOCHASTIC_OSCILLATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STOC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define STOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/stoc_pkg.sv @@
// types and constants shared by the stochastic oscillator modules
`timescale 1ns / 1ps
package stoc_pkg;
	localparam int PRICE_W = 24;
	localparam int PCT_W = 15;
	localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
	localparam int PROD_W = PRICE_W + PCT_W;
	localparam int DIV_CNT_W = $clog2(PCT_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PCT_W - 1);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		KC_ZERO,
		KC_FULL,
		KC_DIVIDE
	} kcls_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_SCAN,
		F_DIFF,
		F_CLASS,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MUL,
		B_LOAD,
		B_DIV,
		B_KSUM,
		B_KMUL,
		B_SSUM,
		B_SMUL,
		B_OUT
	} back_state_t;

	typedef struct packed {
		kcls_t cls;
		logic [PRICE_W-1:0] un;
		logic [PRICE_W-1:0] ud;
		logic kr;
		logic dr;
		logic sr;
	} bar_req_t;
endpackage

@@ hdl/stochastic_oscillator.sv @@
// stochastic oscillator top level: front end, request queue, back end
// the %K divide is a serial divider of 15 steps and runs only for bars that need it
// the front end can take a new bar while the back end still works on earlier ones in the queue
// front end scans its stored high/low window serially for each bar
// reset: asynchronous, clears control state, bar count and both handshakes
`timescale 1ns / 1ps
module stochastic_oscillator #(
	parameter int K_WINDOW = 5,
	parameter int D_WINDOW = 3
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic first_bar,
	input logic [stoc_pkg::PRICE_W-1:0] high_price,
	input logic [stoc_pkg::PRICE_W-1:0] low_price,
	input logic [stoc_pkg::PRICE_W-1:0] close_price,
	output logic out_valid,
	input logic out_ready,
	output logic [stoc_pkg::PCT_W-1:0] fast_k,
	output logic [stoc_pkg::PCT_W-1:0] fast_d,
	output logic [stoc_pkg::PCT_W-1:0] slow_d,
	output logic k_ready,
	output logic d_ready,
	output logic slow_ready
);
	import stoc_pkg::*;

	bar_req_t push_data;
	bar_req_t head;
	logic push, full, pop, empty;

	stoc_front #(
		.K_WINDOW(K_WINDOW),
		.D_WINDOW(D_WINDOW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.first_bar(first_bar),
		.high_price(high_price),
		.low_price(low_price),
		.close_price(close_price),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	stoc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	stoc_back #(
		.D_WINDOW(D_WINDOW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fast_k(fast_k),
		.fast_d(fast_d),
		.slow_d(slow_d),
		.k_ready(k_ready),
		.d_ready(d_ready),
		.slow_ready(slow_ready)
	);
endmodule

@@ hdl/stoc_fifo.sv @@
// short request queue between the bar front end and the arithmetic back end
`timescale 1ns / 1ps
`include "stochastic_oscillator_defines.svh"
module stoc_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input stoc_pkg::bar_req_t push_data,
	output logic full,
	input logic pop,
	output logic empty,
	output stoc_pkg::bar_req_t head
);
	import stoc_pkg::*;

	bar_req_t entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`STOC_ASSERT_IMP(a_no_overflow, push, !full, "request pushed into a full queue")
	`STOC_ASSERT_IMP(a_no_underflow, pop, !empty, "request popped from an empty queue")
endmodule

@@ hdl/stoc_front.sv @@
// front end: takes a bar, scans the high/low window and classifies the %K division
`timescale 1ns / 1ps
module stoc_front #(
	parameter int K_WINDOW = 5,
	parameter int D_WINDOW = 3
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic first_bar,
	input logic [stoc_pkg::PRICE_W-1:0] high_price,
	input logic [stoc_pkg::PRICE_W-1:0] low_price,
	input logic [stoc_pkg::PRICE_W-1:0] close_price,
	output logic push,
	output stoc_pkg::bar_req_t push_data,
	input logic full
);
	import stoc_pkg::*;

	localparam int HIST = K_WINDOW - 1;
	localparam int IDX_W = (HIST > 1) ? $clog2(HIST) : 1;
	localparam int WARM_TOTAL = (K_WINDOW - 1) + 2 * (D_WINDOW - 1);
	localparam int CNT_W = $clog2(WARM_TOTAL + 1);
	localparam logic [CNT_W-1:0] K_START = CNT_W'(K_WINDOW - 1);
	localparam logic [CNT_W-1:0] D_START = CNT_W'(K_WINDOW + D_WINDOW - 2);
	localparam logic [CNT_W-1:0] S_START = CNT_W'(WARM_TOTAL);

	front_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_base;
	logic [IDX_W-1:0] idx_q;
	logic last_idx;
	logic accept;

	logic [PRICE_W-1:0] high_hist [HIST];
	logic [PRICE_W-1:0] low_hist [HIST];
	logic [PRICE_W-1:0] hi_q, lo_q, cl_q, hh_q, ll_q;
	logic [PRICE_W:0] num_q, den_q;
	logic [PRICE_W:0] num_neg, den_neg;
	logic [PRICE_W-1:0] un, ud;
	bar_req_t req_q;

	assign last_idx = (idx_q == IDX_W'(HIST - 1));
	assign cnt_base = first_bar ? '0 : cnt_q;
	assign push_data = req_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (in_valid) state_d = F_SCAN;
			end
			F_SCAN: begin
				if (last_idx) state_d = F_DIFF;
			end
			F_DIFF: state_d = F_CLASS;
			F_CLASS: state_d = F_PUSH;
			F_PUSH: begin
				if (!full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		push = 1'b0;
		case (state_q)
			F_IDLE: in_ready = 1'b1;
			F_PUSH: push = !full;
			default: begin
				in_ready = 1'b0;
				push = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
				cnt_q <= (cnt_base < S_START) ? cnt_base + 1'b1 : cnt_base;
			end else if (state_q == F_SCAN) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// magnitudes of the signed differences
	always_comb begin
		num_neg = -num_q;
		den_neg = -den_q;
		un = num_q[PRICE_W] ? num_neg[PRICE_W-1:0] : num_q[PRICE_W-1:0];
		ud = den_q[PRICE_W] ? den_neg[PRICE_W-1:0] : den_q[PRICE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q <= high_price;
			lo_q <= low_price;
			cl_q <= close_price;
			hh_q <= high_price;
			ll_q <= low_price;
			req_q.kr <= (cnt_base >= K_START);
			req_q.dr <= (cnt_base >= D_START);
			req_q.sr <= (cnt_base >= S_START);
		end
		if (state_q == F_SCAN) begin
			if (high_hist[idx_q] > hh_q) hh_q <= high_hist[idx_q];
			if (low_hist[idx_q] < ll_q) ll_q <= low_hist[idx_q];
		end
		if (state_q == F_DIFF) begin
			num_q <= {1'b0, cl_q} - {1'b0, ll_q};
			den_q <= {1'b0, hh_q} - {1'b0, ll_q};
			high_hist[0] <= hi_q;
			low_hist[0] <= lo_q;
			for (int i = 1; i < HIST; i++) begin
				high_hist[i] <= high_hist[i-1];
				low_hist[i] <= low_hist[i-1];
			end
		end
		if (state_q == F_CLASS) begin
			req_q.un <= un;
			req_q.ud <= ud;
			// zero range reads as full scale; opposite signs or a zero numerator clamp to 0
			if (den_q == '0) begin
				req_q.cls <= KC_FULL;
			end else if (num_q == '0 || num_q[PRICE_W] != den_q[PRICE_W]) begin
				req_q.cls <= KC_ZERO;
			end else if (un >= ud) begin
				req_q.cls <= KC_FULL;
			end else begin
				req_q.cls <= KC_DIVIDE;
			end
		end
	end
endmodule

@@ hdl/stoc_back.sv @@
// back end: serial %K divider, %D and slow %D means, result register
`timescale 1ns / 1ps
`include "stochastic_oscillator_defines.svh"
module stoc_back #(
	parameter int D_WINDOW = 3
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input stoc_pkg::bar_req_t head,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [stoc_pkg::PCT_W-1:0] fast_k,
	output logic [stoc_pkg::PCT_W-1:0] fast_d,
	output logic [stoc_pkg::PCT_W-1:0] slow_d,
	output logic k_ready,
	output logic d_ready,
	output logic slow_ready
);
	import stoc_pkg::*;

	localparam int SUM_W = $clog2(D_WINDOW * 25600 + 1);
	localparam int SHIFT = SUM_W + $clog2(D_WINDOW);
	localparam logic [SHIFT-1:0] RECIP = SHIFT'((2 ** SHIFT + D_WINDOW - 1) / D_WINDOW);
	localparam int MP_W = SUM_W + SHIFT;

	back_state_t state_q, state_d;
	bar_req_t req_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [PROD_W-1:0] prod_q;
	logic [PCT_W-1:0] low_q;
	logic [PRICE_W-1:0] rem_q;
	logic [PCT_W-1:0] quo_q;
	logic [PRICE_W:0] rem_sh, rem_sub;
	logic rem_ge;

	logic [PCT_W-1:0] k_hist [D_WINDOW-1];
	logic [PCT_W-1:0] d_hist [D_WINDOW-1];
	logic [PCT_W-1:0] k_q, d_q;
	logic [PCT_W-1:0] k_val, d_val, s_val;
	logic [SUM_W-1:0] sum_q, k_sum, d_sum;
	logic [MP_W-1:0] mp_q;
	logic out_load;
	logic out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!empty) state_d = (head.cls == KC_DIVIDE) ? B_MUL : B_KSUM;
			end
			B_MUL: state_d = B_LOAD;
			B_LOAD: state_d = B_DIV;
			B_DIV: begin
				if (div_cnt_q == DIV_LAST) state_d = B_KSUM;
			end
			B_KSUM: state_d = B_KMUL;
			B_KMUL: state_d = B_SSUM;
			B_SSUM: state_d = B_SMUL;
			B_SMUL: state_d = B_OUT;
			B_OUT: begin
				if (!out_valid_q || out_ready) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: pop = !empty;
			B_OUT: out_load = !out_valid_q || out_ready;
			default: begin
				pop = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	// one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, low_q[PCT_W-1]};
		rem_ge = (rem_sh >= {1'b0, req_q.ud});
		rem_sub = rem_sh - {1'b0, req_q.ud};
	end

	always_comb begin
		case (req_q.cls)
			KC_FULL: k_val = PCT_FULL;
			KC_DIVIDE: k_val = quo_q;
			default: k_val = '0;
		endcase
		if (!req_q.kr) k_val = '0;
		k_sum = SUM_W'(k_val);
		for (int i = 0; i < D_WINDOW - 1; i++) begin
			k_sum = k_sum + SUM_W'(k_hist[i]);
		end
		// floor of sum / window via the scaled reciprocal
		d_val = req_q.dr ? mp_q[SHIFT +: PCT_W] : '0;
		d_sum = SUM_W'(d_val);
		for (int i = 0; i < D_WINDOW - 1; i++) begin
			d_sum = d_sum + SUM_W'(d_hist[i]);
		end
		s_val = req_q.sr ? mp_q[SHIFT +: PCT_W] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_LOAD) begin
				div_cnt_q <= '0;
			end else if (state_q == B_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop) req_q <= head;
			end
			B_MUL: prod_q <= PROD_W'(req_q.un) * PROD_W'(PCT_FULL);
			B_LOAD: begin
				rem_q <= prod_q[PROD_W-1:PCT_W];
				low_q <= prod_q[PCT_W-1:0];
				quo_q <= '0;
			end
			B_DIV: begin
				rem_q <= rem_ge ? rem_sub[PRICE_W-1:0] : rem_sh[PRICE_W-1:0];
				quo_q <= {quo_q[PCT_W-2:0], rem_ge};
				low_q <= {low_q[PCT_W-2:0], 1'b0};
			end
			B_KSUM: begin
				k_q <= k_val;
				sum_q <= k_sum;
			end
			B_KMUL: mp_q <= MP_W'(sum_q) * MP_W'(RECIP);
			B_SSUM: begin
				d_q <= d_val;
				sum_q <= d_sum;
			end
			B_SMUL: mp_q <= MP_W'(sum_q) * MP_W'(RECIP);
			B_OUT: begin
				if (out_load) begin
					fast_k <= k_q;
					fast_d <= d_q;
					slow_d <= s_val;
					k_ready <= req_q.kr;
					d_ready <= req_q.dr;
					slow_ready <= req_q.sr;
					k_hist[0] <= k_q;
					d_hist[0] <= d_q;
					for (int i = 1; i < D_WINDOW - 1; i++) begin
						k_hist[i] <= k_hist[i-1];
						d_hist[i] <= d_hist[i-1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`STOC_ASSERT_IMP(a_rem_below_divisor, state_q == B_DIV, rem_q < req_q.ud,
		"divider remainder not below divisor")
	`STOC_ASSERT_IMP(a_k_in_range, out_valid, fast_k <= PCT_FULL, "fast_k above full scale")
	`STOC_ASSERT_IMP(a_ready_order, out_valid && slow_ready, d_ready && k_ready,
		"slow_ready raised ahead of the earlier windows")
endmodule
